// ----- hdl/snfcs_pkg.sv -----
// Shared types, codes and constants of the serial NOR flash command sequencer.
`default_nettype none

package snfcs_pkg;

  localparam int ADDR_W = 26;
  localparam int LEN_W  = 17;
  localparam int POS_W  = 18;
  localparam int CAP_W  = 5;

  localparam int PAGE_BYTES_DEF     = 256;
  localparam int MAX_READ_BYTES_DEF = 65536;

  // Depth of the result queue in front of the output channel
  localparam int RES_DEPTH = 4;

  localparam logic [1:0] ACT_CMD  = 2'd0;
  localparam logic [1:0] ACT_HOST = 2'd1;
  localparam logic [1:0] ACT_RX   = 2'd2;
  localparam logic [1:0] ACT_ERR  = 2'd3;

  localparam logic [2:0] CMD_ID     = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_PROG   = 3'd2;
  localparam logic [2:0] CMD_SECTOR = 3'd3;
  localparam logic [2:0] CMD_BLOCK  = 3'd4;
  localparam logic [2:0] CMD_CHIP   = 3'd5;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_HOST = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_LINK    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [7:0] OP_ID     = 8'h90;
  localparam logic [7:0] OP_READ   = 8'h0B;
  localparam logic [7:0] OP_PROG   = 8'h02;
  localparam logic [7:0] OP_SECTOR = 8'h20;
  localparam logic [7:0] OP_BLOCK  = 8'hD8;
  localparam logic [7:0] OP_CHIP   = 8'hC7;
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_RDSR   = 8'h05;
  localparam logic [7:0] OP_UID    = 8'h4B;

  localparam logic [7:0] MFR_ID  = 8'hEF;
  localparam logic [7:0] DEV_MIN = 8'h14;
  localparam logic [7:0] DEV_MAX = 8'h19;
  localparam logic [CAP_W-1:0] CAP_BASE = 5'd21;

  localparam logic [ADDR_W-1:0] SECTOR_MASK = 26'h3FFF000;
  localparam logic [ADDR_W-1:0] BLOCK_MASK  = 26'h3FF0000;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        command;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [7:0]        host_byte;
    logic [7:0]        rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       frame_end;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]       count;
    result_t [1:0]    res;
  } res_pair_t;

  typedef struct packed {
    logic              valid;
    logic              cancel;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } trim_req_t;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] remaining;
  } trim_rsp_t;

  function automatic logic [7:0] opcode_of(input logic [2:0] cmd);
    logic [7:0] op;
    unique case (cmd)
      CMD_ID:     op = OP_ID;
      CMD_READ:   op = OP_READ;
      CMD_PROG:   op = OP_PROG;
      CMD_SECTOR: op = OP_SECTOR;
      CMD_BLOCK:  op = OP_BLOCK;
      CMD_CHIP:   op = OP_CHIP;
      default:    op = 8'h00;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/snfcs_in_if.sv -----
// Input item channel: valid, ready and the fields of one item.
`default_nettype none

interface snfcs_in_if;
  import snfcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [2:0]        command;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;
  logic [7:0]        host_byte;
  logic [7:0]        rx_byte;

  modport source (output valid, action, command, address, length, host_byte, rx_byte,
                  input ready);
  modport sink   (input valid, action, command, address, length, host_byte, rx_byte,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/snfcs_out_if.sv -----
// Result channel: valid, ready and the fields of one result.
`default_nettype none

interface snfcs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic       frame_end;
  logic [1:0] status;
  logic       last;

  modport source (output valid, kind, byte_value, frame_end, status, last, input ready);
  modport sink   (input valid, kind, byte_value, frame_end, status, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/spi_nor_flash_command_sequencer_core.sv -----
// Flow: an accepted item is held in the input register and processed once the result
//   queue has room for a pair; its results are offered from the queue one a transfer.
// Throughput: one item per cycle while items yield at most one result and the output
//   is not stalled; else the output channel, one result a transfer, sets the rate.
// Reset: synchronous, active high; clears the sequencer to idle, not identified,
//   and empties the input register and the result queue.
`default_nettype none

module spi_nor_flash_command_sequencer_core #(
  parameter int PAGE_BYTES     = snfcs_pkg::PAGE_BYTES_DEF,
  parameter int MAX_READ_BYTES = snfcs_pkg::MAX_READ_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  snfcs_in_if.sink     items,
  snfcs_out_if.source  results
);
  import snfcs_pkg::*;

  item_t      item_q;
  logic       item_v;
  logic       room;
  logic       fire;
  trim_req_t  trim_req;
  trim_rsp_t  trim_rsp;
  res_pair_t  res;

  assign fire        = item_v & room;
  assign items.ready = ~item_v | room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (items.valid && items.ready) begin
      item_v <= 1'b1;
    end else if (fire) begin
      item_v <= 1'b0;
    end
    if (items.valid && items.ready) begin
      item_q <= '{action: items.action, command: items.command, address: items.address,
                  length: items.length, host_byte: items.host_byte, rx_byte: items.rx_byte};
    end
  end

  snfcs_engine #(
    .MAX_READ_BYTES (MAX_READ_BYTES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (item_q),
    .trim_rsp (trim_rsp),
    .trim_req (trim_req),
    .res      (res)
  );

  snfcs_page_trim #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_page_trim (
    .clk (clk),
    .rst (rst),
    .req (trim_req),
    .rsp (trim_rsp)
  );

  snfcs_result_fifo u_result_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (res),
    .room    (room),
    .results (results)
  );

endmodule

`default_nettype wire

// ----- hdl/snfcs_page_trim.sv -----
// Page-end trim of a program length: remainder by the page size over two stages.
`default_nettype none

module snfcs_page_trim #(
  parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  snfcs_pkg::trim_req_t  req,
  output snfcs_pkg::trim_rsp_t  rsp
);
  import snfcs_pkg::*;

  localparam int PG_L  = $clog2(PAGE_BYTES);
  localparam int PG_W  = $clog2(PAGE_BYTES + 1);
  localparam int SH    = ADDR_W + PG_L;
  localparam int REC_W = ADDR_W + 2;
  localparam int PR_W  = ADDR_W + REC_W;
  localparam int Q_W   = PR_W - SH;
  // Rounded-up reciprocal: exact quotient for every address of ADDR_W bits
  localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [REC_W-1:0] RECIP = RECIP_WIDE[REC_W-1:0];
  localparam logic [PG_W-1:0]  PAGE  = PG_W'(PAGE_BYTES);

  logic                   v1, v2;
  logic [ADDR_W-1:0]      addr1, addr2;
  logic [LEN_W-1:0]       len1, len2;
  logic [Q_W-1:0]         q1;
  logic [ADDR_W-1:0]      qp2;
  logic [PR_W-1:0]        prod1;
  logic [Q_W+PG_W-1:0]    prod2;
  logic [ADDR_W-1:0]      diff;
  logic [PG_W-1:0]        room;
  logic [LEN_W-1:0]       room_len;

  assign prod1 = req.addr * RECIP;
  assign prod2 = q1 * PAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1 & ~req.cancel;
    end
    if (req.valid) begin
      addr1 <= req.addr;
      len1  <= req.len;
      q1    <= prod1[PR_W-1:SH];
    end
    if (v1) begin
      addr2 <= addr1;
      len2  <= len1;
      qp2   <= prod2[ADDR_W-1:0];
    end
  end

  assign diff     = addr2 - qp2;
  assign room     = PAGE - diff[PG_W-1:0];
  assign room_len = LEN_W'(room);

  assign rsp.valid     = v2 & ~req.cancel;
  assign rsp.remaining = (len2 < room_len) ? len2 : room_len;

endmodule

`default_nettype wire

// ----- hdl/snfcs_engine.sv -----
// Command sequencer state and per-item next-state logic, up to two results an item.
`default_nettype none

module snfcs_engine #(
  parameter int MAX_READ_BYTES = snfcs_pkg::MAX_READ_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  snfcs_pkg::item_t      item,
  input  snfcs_pkg::trim_rsp_t  trim_rsp,
  output snfcs_pkg::trim_req_t  trim_req,
  output snfcs_pkg::res_pair_t  res
);
  import snfcs_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ID, PH_UID, PH_WREN, PH_READ, PH_PROG_HDR,
    PH_PROG_WAIT, PH_PROG_DATA, PH_ERASE, PH_POLL
  } phase_t;

  localparam logic [31:0]      MAX_RD   = 32'(MAX_READ_BYTES);
  localparam logic [POS_W-1:0] ID_LAST  = POS_W'(5);
  localparam logic [POS_W-1:0] UID_DATA = POS_W'(5);
  localparam logic [POS_W-1:0] UID_LAST = POS_W'(12);
  localparam logic [POS_W-1:0] RD_HDR   = POS_W'(5);
  localparam logic [POS_W-1:0] ADDR_HDR = POS_W'(4);

  phase_t            phase, phase_next;
  logic [CAP_W-1:0]  cap_log2, cap_next;
  logic [2:0]        active_command, act_next;
  logic [POS_W-1:0]  frame_position, pos_next;
  logic [ADDR_W-1:0] target_address, tgt_next;
  logic [LEN_W-1:0]  remaining_bytes, rem_next;

  logic [ADDR_W:0]   cap_val, span;
  logic [POS_W-1:0]  total, nxt;
  logic [7:0]        hdr, dev_off;
  logic [LEN_W-1:0]  rem_dec;
  logic              start, trim_go;
  logic              lead_v, tail_v;
  result_t           lead, tail, r0, r1;

  function automatic result_t mk_send(input logic [7:0] b, input logic fe);
    return '{kind: KIND_SEND, byte_value: b, frame_end: fe, status: ST_OK, last: 1'b0};
  endfunction

  function automatic result_t mk_done(input logic [1:0] st);
    return '{kind: KIND_DONE, byte_value: 8'h00, frame_end: 1'b0, status: st, last: 1'b0};
  endfunction

  assign cap_val = (cap_log2 == '0) ? '0 : ({{ADDR_W{1'b0}}, 1'b1} << cap_log2);
  assign span    = {1'b0, item.address} + (ADDR_W + 1)'(item.length);
  assign nxt     = frame_position + POS_W'(1);
  assign dev_off = item.rx_byte - DEV_MIN;
  assign rem_dec = (remaining_bytes != '0) ? remaining_bytes - LEN_W'(1) : remaining_bytes;

  always_comb begin
    if (active_command == CMD_READ) total = POS_W'(remaining_bytes) + RD_HDR;
    else if (active_command == CMD_CHIP) total = POS_W'(1);
    else total = ADDR_HDR;
  end

  // Address bytes follow the opcode, most significant first
  assign hdr = (nxt == POS_W'(1)) ? target_address[23:16] :
               (nxt == POS_W'(2)) ? target_address[15:8]  :
               (nxt == POS_W'(3)) ? target_address[7:0]   : 8'h00;

  always_comb begin
    phase_next = phase;
    cap_next   = cap_log2;
    act_next   = active_command;
    pos_next   = frame_position;
    tgt_next   = target_address;
    rem_next   = remaining_bytes;
    start      = 1'b0;
    trim_go    = 1'b0;
    lead_v     = 1'b0;
    lead       = '{kind: KIND_HOST, byte_value: item.rx_byte, frame_end: 1'b0,
                   status: ST_OK, last: 1'b0};
    tail_v     = 1'b0;
    tail       = '0;

    if (trim_rsp.valid) rem_next = trim_rsp.remaining;

    if (fire) begin
      unique case (item.action)
        ACT_CMD: begin
          if (phase == PH_IDLE) begin
            start    = 1'b1;
            act_next = item.command;
            pos_next = '0;
            tail_v   = 1'b1;
            unique case (item.command)
              CMD_ID: begin
                tgt_next   = '0;
                phase_next = PH_ID;
                tail       = mk_send(OP_ID, 1'b0);
              end
              CMD_READ: begin
                if (item.length == '0 || 32'(item.length) > MAX_RD || span > cap_val) begin
                  tail = mk_done(ST_REJECT);
                end else begin
                  tgt_next   = item.address;
                  rem_next   = item.length;
                  phase_next = PH_READ;
                  tail       = mk_send(OP_READ, 1'b0);
                end
              end
              CMD_PROG: begin
                if (item.length == '0 || span > cap_val) begin
                  tail = mk_done(ST_REJECT);
                end else begin
                  tgt_next   = item.address;
                  trim_go    = 1'b1;
                  phase_next = PH_WREN;
                  tail       = mk_send(OP_WREN, 1'b1);
                end
              end
              CMD_SECTOR, CMD_BLOCK: begin
                if ({1'b0, item.address} >= cap_val) begin
                  tail = mk_done(ST_REJECT);
                end else begin
                  tgt_next   = item.address &
                               ((item.command == CMD_SECTOR) ? SECTOR_MASK : BLOCK_MASK);
                  phase_next = PH_WREN;
                  tail       = mk_send(OP_WREN, 1'b1);
                end
              end
              CMD_CHIP: begin
                tgt_next   = '0;
                phase_next = PH_WREN;
                tail       = mk_send(OP_WREN, 1'b1);
              end
              default: tail = mk_done(ST_REJECT);
            endcase
          end
        end
        ACT_HOST: begin
          if (phase == PH_PROG_WAIT) begin
            phase_next = PH_PROG_DATA;
            tail_v     = 1'b1;
            tail       = mk_send(item.host_byte, remaining_bytes <= LEN_W'(1));
          end
        end
        ACT_RX: begin
          unique case (phase)
            PH_ID: begin
              tail_v = 1'b1;
              if (frame_position < ID_LAST) begin
                if (frame_position == ID_LAST - POS_W'(1))
                  tgt_next = ADDR_W'(item.rx_byte);
                pos_next = nxt;
                tail     = mk_send(8'h00, nxt == ID_LAST);
              end else if (target_address == ADDR_W'(MFR_ID) &&
                           item.rx_byte >= DEV_MIN && item.rx_byte <= DEV_MAX) begin
                cap_next   = CAP_BASE + dev_off[CAP_W-1:0];
                phase_next = PH_UID;
                pos_next   = '0;
                tail       = mk_send(OP_UID, 1'b0);
              end else begin
                phase_next = PH_IDLE;
                pos_next   = '0;
                tail       = mk_done(ST_UNKNOWN);
              end
            end
            PH_UID: begin
              lead_v = (frame_position >= UID_DATA);
              tail_v = 1'b1;
              if (frame_position < UID_LAST) begin
                pos_next = nxt;
                tail     = mk_send(8'h00, nxt == UID_LAST);
              end else begin
                phase_next = PH_IDLE;
                pos_next   = '0;
                tail       = mk_done(ST_OK);
              end
            end
            PH_WREN: begin
              phase_next = (active_command == CMD_PROG) ? PH_PROG_HDR : PH_ERASE;
              pos_next   = '0;
              tail_v     = 1'b1;
              tail       = mk_send(opcode_of(active_command), active_command == CMD_CHIP);
            end
            PH_READ, PH_PROG_HDR, PH_ERASE: begin
              lead_v = (phase == PH_READ) && (frame_position >= RD_HDR);
              if (nxt < total) begin
                pos_next = nxt;
                tail_v   = 1'b1;
                tail     = mk_send(hdr, phase != PH_PROG_HDR && nxt == total - POS_W'(1));
              end else if (phase == PH_READ) begin
                phase_next = PH_IDLE;
                pos_next   = '0;
                tail_v     = 1'b1;
                tail       = mk_done(ST_OK);
              end else if (phase == PH_PROG_HDR) begin
                phase_next = PH_PROG_WAIT;
              end else begin
                phase_next = PH_POLL;
                pos_next   = '0;
                tail_v     = 1'b1;
                tail       = mk_send(OP_RDSR, 1'b0);
              end
            end
            PH_PROG_DATA: begin
              rem_next = rem_dec;
              if (rem_dec != '0) begin
                phase_next = PH_PROG_WAIT;
              end else begin
                phase_next = PH_POLL;
                pos_next   = '0;
                tail_v     = 1'b1;
                tail       = mk_send(OP_RDSR, 1'b0);
              end
            end
            PH_POLL: begin
              tail_v = 1'b1;
              if (frame_position == '0) begin
                pos_next = POS_W'(1);
                tail     = mk_send(8'h00, 1'b1);
              end else if (item.rx_byte[0]) begin
                // Still busy: poll again
                pos_next = '0;
                tail     = mk_send(OP_RDSR, 1'b0);
              end else begin
                phase_next = PH_IDLE;
                pos_next   = '0;
                tail       = mk_done(ST_OK);
              end
            end
            default: ;
          endcase
        end
        ACT_ERR: begin
          if (phase != PH_IDLE) begin
            phase_next = PH_IDLE;
            pos_next   = '0;
            tail_v     = 1'b1;
            tail       = mk_done(ST_LINK);
          end
        end
      endcase
    end
  end

  // Pack the host byte ahead of the frame byte or done, and mark the final one
  always_comb begin
    r0 = lead_v ? lead : tail;
    r1 = tail;
    if (lead_v && tail_v) r1.last = 1'b1;
    else r0.last = 1'b1;
    res.count  = {1'b0, lead_v} + {1'b0, tail_v};
    res.res[0] = r0;
    res.res[1] = r1;
  end

  assign trim_req.valid  = trim_go;
  assign trim_req.cancel = start;
  assign trim_req.addr   = item.address;
  assign trim_req.len    = item.length;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      cap_log2        <= '0;
      active_command  <= '0;
      frame_position  <= '0;
      target_address  <= '0;
      remaining_bytes <= '0;
    end else begin
      phase           <= phase_next;
      cap_log2        <= cap_next;
      active_command  <= act_next;
      frame_position  <= pos_next;
      target_address  <= tgt_next;
      remaining_bytes <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/snfcs_result_fifo.sv -----
// Result queue: takes up to two results a cycle, hands one a transfer to the output.
`default_nettype none

module snfcs_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  snfcs_pkg::res_pair_t  push,
  output logic                  room,
  snfcs_out_if.source           results
);
  import snfcs_pkg::*;

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  result_t            entries [RES_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;
  result_t            head;

  assign pop  = results.valid & results.ready;
  assign head = entries[rd_ptr];
  // Room for a full pair regardless of this cycle's transfer
  assign room = (count <= CNT_W'(RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
    if (push.count != 2'd0) entries[wr_ptr] <= push.res[0];
    if (push.count == 2'd2) entries[wr_ptr + PTR_W'(1)] <= push.res[1];
  end

  assign results.valid      = (count != '0);
  assign results.kind       = head.kind;
  assign results.byte_value = head.byte_value;
  assign results.frame_end  = head.frame_end;
  assign results.status     = head.status;
  assign results.last       = head.last;

endmodule

`default_nettype wire

// ----- hdl/snfcs_checker.sv -----
// Port checker for the sequencer core and its bind to the top level.
`default_nettype none

module snfcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] kind,
  input logic [7:0] byte_value,
  input logic       frame_end,
  input logic [1:0] status,
  input logic       last
);
  import snfcs_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable({kind, byte_value, frame_end, status, last}))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered straight after reset");

  // A done closes the item's results and carries no byte
  a_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_DONE |-> last && byte_value == 8'h00 && !frame_end)
    else $error("malformed done result");

  a_side: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_DONE |-> status == ST_OK && (kind == KIND_SEND || !frame_end))
    else $error("status or frame end on a byte result");

endmodule

bind spi_nor_flash_command_sequencer_core snfcs_checker u_snfcs_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .kind       (results.kind),
  .byte_value (results.byte_value),
  .frame_end  (results.frame_end),
  .status     (results.status),
  .last       (results.last)
);

`default_nettype wire
